FILE: rtl/longest_prefix_match_route_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the route table
// Shared concurrent-check forms used by the route table top.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_MACROS_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LPMRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LPMRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpmrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Types, field widths and helper functions shared by the route table RTL.
// ----------------------------------------------------------------------------
package lpmrt_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int PORT_W     = 8;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] nexthop;
        logic [PORT_W-1:0] port;
    } entry_t;

    // Per-entry verdict of the compare unit.
    typedef struct packed {
        logic key_hit;
        logic free;
        logic better;
    } match_t;

    // Keep the top len bits of an address.
    function automatic logic [ADDR_W-1:0] top_mask(input logic [LEN_W-1:0] len);
        top_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

FILE: rtl/longest_prefix_match_route_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 longest-prefix-match route table
// Insert, delete and lookup of routes over a TABLE_DEPTH-entry memory.
// ----------------------------------------------------------------------------
// Every command (query, insert/replace, delete) is one input transfer and
// returns one result transfer. A query, and an insert or delete whose prefix
// length is 0..32, walks the whole entry memory once through a single compare
// unit, one entry per cycle, before its result is offered; the next command
// is taken only once that result is loaded into the output register. An
// insert or delete with a length above 32, and command 3, skip the walk.
// s_axis_tready is high only while the block is idle, and a finished result
// waits in the output register while the next command is already taken.
// After reset the block writes every entry invalid, one entry per cycle, so
// s_axis_tready stays low through that clearing pass. Insert takes the entry
// with the same key, or else the lowest free one; a full table reports
// status 1. Query returns the valid route with the longest matching length.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_route_table_top_macros.svh"

module longest_prefix_match_route_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] key_addr, [37:32] prefix_len, [69:38] new_nexthop,
    // [77:70] new_port, [79:78] zero
    input  logic [lpmrt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [lpmrt_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] hit, [32:1] found_nexthop, [40:33] found_port, [41] status,
    // [47:42] zero
    output logic [lpmrt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int ADDR_W = lpmrt_pkg::ADDR_W;
    localparam int LEN_W  = lpmrt_pkg::LEN_W;
    localparam int PORT_W = lpmrt_pkg::PORT_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // FSM
    lpmrt_pkg::state_t state_reg, state_next;

    // Command held for the whole walk
    lpmrt_pkg::cmd_t    cmd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ADDR_W-1:0]  nh_reg;
    logic [PORT_W-1:0]  port_reg;

    // Walk control
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               issue_done_reg;
    logic               rd_vld_reg;
    logic               rd_last_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   clr_idx_reg;

    // Walk results
    logic               key_found_reg;
    logic [IDX_W-1:0]   key_slot_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_slot_reg;
    logic               best_hit_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic [ADDR_W-1:0]  best_nh_reg;
    logic [PORT_W-1:0]  best_port_reg;

    // Output register
    logic                                   m_valid_reg;
    logic [lpmrt_pkg::OUT_DATA_W-1:0]       m_data_reg;

    // Memory and compare unit hookup
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    lpmrt_pkg::entry_t  mem_wr_data;
    logic               mem_rd_en;
    lpmrt_pkg::entry_t  mem_rd_data;
    lpmrt_pkg::match_t  match;

    logic s_xfer;
    logic len_ok;
    logic scan_end;
    logic out_free;
    logic res_hit;
    logic res_status;
    lpmrt_pkg::cmd_t in_cmd;

    assign in_cmd   = lpmrt_pkg::cmd_t'(s_axis_tuser);
    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign len_ok   = (len_reg <= LEN_W'(ADDR_W));
    assign scan_end = rd_vld_reg && rd_last_reg;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == lpmrt_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // One read a cycle while walking.
    assign mem_rd_en = (state_reg == lpmrt_pkg::ST_SCAN) && !issue_done_reg;

    lpmrt_mem #(
        .DEPTH   (TABLE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (mem_rd_data)
    );

    lpmrt_match u_match (
        .entry    (mem_rd_data),
        .key_addr (addr_reg),
        .key_len  (len_reg),
        .best_hit (best_hit_reg),
        .best_len (best_len_reg),
        .result   (match)
    );

    // Write port: clearing pass, insert and delete.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_idx_reg;
        mem_wr_data = '0;
        if (state_reg == lpmrt_pkg::ST_CLEAR) begin
            mem_wr_en = 1'b1;
        end else if (state_reg == lpmrt_pkg::ST_WRITE) begin
            mem_wr_addr         = key_found_reg ? key_slot_reg : free_slot_reg;
            mem_wr_data.prefix  = addr_reg;
            mem_wr_data.length  = len_reg;
            mem_wr_data.nexthop = nh_reg;
            mem_wr_data.port    = port_reg;
            if (cmd_reg == lpmrt_pkg::CMD_INSERT) begin
                // Replace the same key, else fill the lowest free entry.
                mem_wr_en         = key_found_reg || free_found_reg;
                mem_wr_data.valid = 1'b1;
            end else if (cmd_reg == lpmrt_pkg::CMD_DELETE) begin
                mem_wr_en         = key_found_reg;
                mem_wr_data.valid = 1'b0;
            end
        end
    end

    // Result fields; all zero for anything but a query hit or a full table.
    assign res_hit    = (cmd_reg == lpmrt_pkg::CMD_QUERY) && best_hit_reg;
    assign res_status = (cmd_reg == lpmrt_pkg::CMD_INSERT) && len_ok
                        && !key_found_reg && !free_found_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpmrt_pkg::ST_CLEAR: begin
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = lpmrt_pkg::ST_IDLE;
                end
            end
            lpmrt_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    // Skip the walk for commands that cannot touch the table.
                    if ((in_cmd == lpmrt_pkg::CMD_QUERY)
                        || (((in_cmd == lpmrt_pkg::CMD_INSERT)
                             || (in_cmd == lpmrt_pkg::CMD_DELETE))
                            && (s_axis_tdata[37:32] <= LEN_W'(ADDR_W)))) begin
                        state_next = lpmrt_pkg::ST_SCAN;
                    end else begin
                        state_next = lpmrt_pkg::ST_FINISH;
                    end
                end
            end
            lpmrt_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = lpmrt_pkg::ST_WRITE;
                end
            end
            lpmrt_pkg::ST_WRITE: begin
                state_next = lpmrt_pkg::ST_FINISH;
            end
            lpmrt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = lpmrt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpmrt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpmrt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (state_reg == lpmrt_pkg::ST_CLEAR) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Capture the command on the input transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg  <= in_cmd;
            addr_reg <= s_axis_tdata[31:0];
            len_reg  <= s_axis_tdata[37:32];
            nh_reg   <= s_axis_tdata[69:38];
            port_reg <= s_axis_tdata[77:70];
        end
    end

    // Read issue and read-data tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
        end else begin
            rd_vld_reg  <= mem_rd_en;
            rd_last_reg <= mem_rd_en && (scan_idx_reg == LAST_IDX);
            if (s_xfer) begin
                scan_idx_reg   <= '0;
                issue_done_reg <= 1'b0;
            end else if (mem_rd_en) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    issue_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_idx_reg <= scan_idx_reg;
        end
    end

    // Fold each entry read into the running results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_hit_reg   <= 1'b0;
        end else if (s_xfer) begin
            key_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_hit_reg   <= 1'b0;
        end else if (rd_vld_reg) begin
            if (match.key_hit && !key_found_reg) begin
                key_found_reg <= 1'b1;
            end
            if (match.free && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
            if (match.better) begin
                best_hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            if (match.key_hit && !key_found_reg) begin
                key_slot_reg <= rd_idx_reg;
            end
            // Lowest free index wins since the walk runs upward.
            if (match.free && !free_found_reg) begin
                free_slot_reg <= rd_idx_reg;
            end
            if (match.better) begin
                best_len_reg  <= mem_rd_data.length;
                best_nh_reg   <= mem_rd_data.nexthop;
                best_port_reg <= mem_rd_data.port;
            end
        end
    end

    // Output register: load on finish, drop on the output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == lpmrt_pkg::ST_FINISH) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == lpmrt_pkg::ST_FINISH) && out_free) begin
            m_data_reg <= {6'b0,
                           res_status,
                           res_hit ? best_port_reg : {PORT_W{1'b0}},
                           res_hit ? best_nh_reg : {ADDR_W{1'b0}},
                           res_hit};
        end
    end

    // Checks
    `LPMRT_ASSERT_IMP(a_wr_only_clear_or_write, aclk, aresetn, mem_wr_en, (state_reg == lpmrt_pkg::ST_CLEAR) || (state_reg == lpmrt_pkg::ST_WRITE), "memory written outside clear or write-back")
    `LPMRT_ASSERT_IMP(a_rd_data_in_scan, aclk, aresetn, rd_vld_reg, state_reg == lpmrt_pkg::ST_SCAN, "read data returned outside the walk")
    `LPMRT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_xfer, !s_axis_tready, "ready held after a command transfer")
    `LPMRT_ASSERT_IMP(a_full_no_write, aclk, aresetn, (state_reg == lpmrt_pkg::ST_WRITE) && !key_found_reg && !free_found_reg, !mem_wr_en, "write issued with no target entry")

endmodule

FILE: rtl/lpmrt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpmrt_mem #(
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  lpmrt_pkg::entry_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output lpmrt_pkg::entry_t rd_data
);

    lpmrt_pkg::entry_t mem_array [DEPTH];
    lpmrt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lpmrt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table compare unit
// Checks one entry for exact key, free slot and better prefix match.
// ----------------------------------------------------------------------------
module lpmrt_match (
    input  lpmrt_pkg::entry_t                entry,
    input  logic [lpmrt_pkg::ADDR_W-1:0]     key_addr,
    input  logic [lpmrt_pkg::LEN_W-1:0]      key_len,
    input  logic                             best_hit,
    input  logic [lpmrt_pkg::LEN_W-1:0]      best_len,
    output lpmrt_pkg::match_t                result
);

    logic pfx_match;

    assign pfx_match = (entry.prefix == (key_addr & lpmrt_pkg::top_mask(entry.length)));

    always_comb begin
        result.key_hit = entry.valid && (entry.prefix == key_addr)
                         && (entry.length == key_len);
        result.free    = !entry.valid;
        // Stored prefixes with host bits never equal a masked address.
        result.better  = entry.valid && pfx_match
                         && (!best_hit || (entry.length > best_len));
    end

endmodule
